/* sv/masked_signal_dispatch_queue_macros.svh */
// assertion macros for the masked signal dispatch queue
// used by masked_signal_dispatch_queue.sv, no other dependencies
`ifndef MASKED_SIGNAL_DISPATCH_QUEUE_MACROS_SVH
`define MASKED_SIGNAL_DISPATCH_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define MSDQ_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MSDQ_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MSDQ_ASSERT_IMP(name, ck, rn, ante, cons)
`define MSDQ_ASSERT_NXT(name, ck, rn, ante, cons)
`endif
`endif

/* sv/msdq_pkg.sv */
// shared types and constants of the masked signal dispatch queue
// no dependencies
package msdq_pkg;

  localparam int CMD_W       = 4;
  localparam int SIG_W       = 4;
  localparam int HID_W       = 8;
  localparam int PEND_W      = 4;
  localparam int MAX_RESULTS = 32;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD        = 4'd0,
    CMD_CLEAR      = 4'd1,
    CMD_SWAP       = 4'd2,
    CMD_BLOCK      = 4'd3,
    CMD_UNBLOCK    = 4'd4,
    CMD_GBLOCK     = 4'd5,
    CMD_GUNBLOCK   = 4'd6,
    CMD_RAISE      = 4'd7,
    CMD_DELIVER    = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_INVOKE = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_WR2,
    S_DSCAN,
    S_DHAND,
    S_DEND
  } state_t;

endpackage

/* sv/masked_signal_dispatch_queue.sv */
// simple commands (block, raise, clear, bad ones): result in the cycle after acceptance, busy stays low
// add and swap: one memory read per cycle while the list is scanned, then an exec state, and a
// second write state when a swap writes; deliver: a scan state per queued entry, the handler list
// of each unblocked entry read in turn, then an end state; handler memory reads set the pace, no stalls
// reset is synchronous active low: counts, block bits, queue count cleared; handler memory not
// cleared, entries are only read below a list's count
`include "masked_signal_dispatch_queue_macros.svh"
module masked_signal_dispatch_queue #(
  parameter int NUM_SIGNALS  = 16,
  parameter int QUEUE_DEPTH  = 8,
  parameter int MAX_HANDLERS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [msdq_pkg::CMD_W-1:0]   in_cmd,
  input  logic [msdq_pkg::SIG_W-1:0]   in_signal_num,
  input  logic [msdq_pkg::HID_W-1:0]   in_handler_first,
  input  logic [msdq_pkg::HID_W-1:0]   in_handler_second,
  output logic                         out_valid,
  output logic [1:0]                   out_kind,
  output logic [msdq_pkg::SIG_W-1:0]   out_signal,
  output logic [msdq_pkg::HID_W-1:0]   out_handler,
  output logic [1:0]                   out_status,
  output logic [msdq_pkg::PEND_W-1:0]  out_pending,
  output logic                         out_last
);
  import msdq_pkg::*;

  localparam int SIDX_W    = $clog2(NUM_SIGNALS);
  localparam int HIDX_W    = (MAX_HANDLERS > 1) ? $clog2(MAX_HANDLERS) : 1;
  localparam int HCNT_W    = $clog2(MAX_HANDLERS + 1);
  localparam int QIDX_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = NUM_SIGNALS * MAX_HANDLERS;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  state_t state_r, state_nxt;

  logic [HCNT_W-1:0] hcnt_r [NUM_SIGNALS];
  logic [HCNT_W-1:0] hcnt_nxt [NUM_SIGNALS];
  logic [NUM_SIGNALS-1:0] lblk_r, lblk_nxt, gblk_r, gblk_nxt;
  logic [SIDX_W-1:0] fifo_r [QUEUE_DEPTH];
  logic [SIDX_W-1:0] fifo_nxt [QUEUE_DEPTH];
  logic [QCNT_W-1:0] pcnt_r, pcnt_nxt;

  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [SIDX_W-1:0] sig_r, sig_nxt;
  logic [HID_W-1:0]  h1_r, h1_nxt, h2_r, h2_nxt;
  logic [HCNT_W-1:0] idx_r, idx_nxt, len_r, len_nxt;
  logic              rv_r, rv_nxt;
  logic [HIDX_W-1:0] ridx_r, ridx_nxt, fa_r, fa_nxt, fb_r, fb_nxt;
  logic              fav_r, fav_nxt, fbv_r, fbv_nxt;
  logic [QCNT_W-1:0] qi_r, qi_nxt, keep_r, keep_nxt, pfin_r, pfin_nxt;
  logic [RES_W-1:0]  ninv_r, ninv_nxt;
  logic              hold_v_r, hold_v_nxt;
  logic [SIDX_W-1:0] hold_sig_r, hold_sig_nxt;
  logic [HID_W-1:0]  hold_h_r, hold_h_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic [SIG_W-1:0]  out_signal_r, out_signal_nxt;
  logic [HID_W-1:0]  out_handler_r, out_handler_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [PEND_W-1:0] out_pending_r, out_pending_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [HID_W-1:0]  ram_wdata, ram_q;

  logic              accept, sig_ok, swap_ok, q_blocked;
  logic [SIDX_W-1:0] in_sidx, q_sig;

  function automatic logic [RAM_AW-1:0] addr_of(logic [SIDX_W-1:0] s, logic [HCNT_W-1:0] i);
    addr_of = RAM_AW'(RAM_AW'(s) * RAM_AW'(MAX_HANDLERS) + RAM_AW'(i));
  endfunction

  function automatic logic [PEND_W-1:0] sat_pend(logic [QCNT_W-1:0] v);
    sat_pend = (int'(v) > 15) ? PEND_W'(15) : PEND_W'(v);
  endfunction

  msdq_hram #(.DEPTH(RAM_DEPTH)) u_hram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign sig_ok    = int'(in_signal_num) < NUM_SIGNALS;
  assign in_sidx   = SIDX_W'(in_signal_num);
  assign swap_ok   = fav_r && fbv_r && (fa_r != fb_r);
  assign q_sig     = fifo_r[QIDX_W'(qi_r)];
  assign q_blocked = lblk_r[q_sig] || gblk_r[q_sig];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_DELIVER) begin
            state_nxt = S_DSCAN;
          end else if (sig_ok && (in_cmd == CMD_ADD || in_cmd == CMD_SWAP)) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_r == len_r && !rv_r) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = (cmd_r == CMD_SWAP && swap_ok) ? S_WR2 : S_IDLE;
      end
      S_WR2:  state_nxt = S_IDLE;
      S_DSCAN: begin
        if (qi_r == pcnt_r) begin
          state_nxt = S_DEND;
        end else if (!q_blocked) begin
          state_nxt = S_DHAND;
        end
      end
      S_DHAND: begin
        if (idx_r == len_r && !rv_r) state_nxt = S_DSCAN;
      end
      S_DEND:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    logic [QCNT_W-1:0] nblk;
    hcnt_nxt     = hcnt_r;
    lblk_nxt     = lblk_r;
    gblk_nxt     = gblk_r;
    fifo_nxt     = fifo_r;
    pcnt_nxt     = pcnt_r;
    cmd_nxt      = cmd_r;
    sig_nxt      = sig_r;
    h1_nxt       = h1_r;
    h2_nxt       = h2_r;
    idx_nxt      = idx_r;
    len_nxt      = len_r;
    rv_nxt       = 1'b0;
    ridx_nxt     = ridx_r;
    fa_nxt       = fa_r;
    fb_nxt       = fb_r;
    fav_nxt      = fav_r;
    fbv_nxt      = fbv_r;
    qi_nxt       = qi_r;
    keep_nxt     = keep_r;
    pfin_nxt     = pfin_r;
    ninv_nxt     = ninv_r;
    hold_v_nxt   = hold_v_r;
    hold_sig_nxt = hold_sig_r;
    hold_h_nxt   = hold_h_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = addr_of(sig_r, idx_r);
    out_valid_nxt   = 1'b0;
    out_kind_nxt    = KIND_ACK;
    out_signal_nxt  = SIG_W'(sig_r);
    out_handler_nxt = '0;
    out_status_nxt  = ST_DONE;
    out_pending_nxt = sat_pend(pcnt_r);
    out_last_nxt    = 1'b1;
    nblk            = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_cmd;
          sig_nxt  = in_sidx;
          h1_nxt   = in_handler_first;
          h2_nxt   = in_handler_second;
          idx_nxt  = '0;
          fav_nxt  = 1'b0;
          fbv_nxt  = 1'b0;
          len_nxt  = sig_ok ? hcnt_r[in_sidx] : '0;
          out_signal_nxt = in_signal_num;
          priority if (in_cmd == CMD_DELIVER) begin
            qi_nxt     = '0;
            keep_nxt   = '0;
            ninv_nxt   = '0;
            hold_v_nxt = 1'b0;
            // queue count left once blocked entries are kept back
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if (i < int'(pcnt_r) && (lblk_r[fifo_r[i]] || gblk_r[fifo_r[i]])) begin
                nblk = QCNT_W'(nblk + 1'b1);
              end
            end
            pfin_nxt = nblk;
          end else if (in_cmd > CMD_DELIVER || !sig_ok) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_IGNORED;
          end else begin
            unique case (in_cmd)
              CMD_CLEAR: begin
                hcnt_nxt[in_sidx] = '0;
                out_valid_nxt = 1'b1;
              end
              CMD_BLOCK: begin
                lblk_nxt[in_sidx] = 1'b1;
                out_valid_nxt = 1'b1;
              end
              CMD_UNBLOCK: begin
                lblk_nxt[in_sidx] = 1'b0;
                out_valid_nxt = 1'b1;
              end
              CMD_GBLOCK: begin
                gblk_nxt[in_sidx] = 1'b1;
                out_valid_nxt = 1'b1;
              end
              CMD_GUNBLOCK: begin
                gblk_nxt[in_sidx] = 1'b0;
                out_valid_nxt = 1'b1;
              end
              CMD_RAISE: begin
                out_valid_nxt = 1'b1;
                if (hcnt_r[in_sidx] == '0) begin
                  out_status_nxt = ST_IGNORED;
                end else if (int'(pcnt_r) >= QUEUE_DEPTH) begin
                  out_status_nxt = ST_DROPPED;
                end else begin
                  fifo_nxt[QIDX_W'(pcnt_r)] = in_sidx;
                  pcnt_nxt        = QCNT_W'(pcnt_r + 1'b1);
                  out_pending_nxt = sat_pend(QCNT_W'(pcnt_r + 1'b1));
                end
              end
              default: begin
                // add and swap walk the list first
              end
            endcase
          end
        end
      end

      S_SCAN: begin
        if (idx_r != len_r) begin
          ram_re   = 1'b1;
          rv_nxt   = 1'b1;
          ridx_nxt = HIDX_W'(idx_r);
          idx_nxt  = HCNT_W'(idx_r + 1'b1);
        end
        if (rv_r) begin
          if (ram_q == h1_r) begin
            fav_nxt = 1'b1;
            fa_nxt  = ridx_r;
          end
          if (ram_q == h2_r) begin
            fbv_nxt = 1'b1;
            fb_nxt  = ridx_r;
          end
        end
      end

      S_EXEC: begin
        if (cmd_r == CMD_ADD) begin
          out_valid_nxt = 1'b1;
          if (h1_r == '0 || fav_r) begin
            out_status_nxt = ST_IGNORED;
          end else if (int'(len_r) >= MAX_HANDLERS) begin
            out_status_nxt = ST_DROPPED;
          end else begin
            ram_we           = 1'b1;
            ram_waddr        = addr_of(sig_r, len_r);
            ram_wdata        = h1_r;
            hcnt_nxt[sig_r]  = HCNT_W'(len_r + 1'b1);
          end
        end else if (swap_ok) begin
          ram_we    = 1'b1;
          ram_waddr = addr_of(sig_r, HCNT_W'(fa_r));
          ram_wdata = h2_r;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_IGNORED;
        end
      end

      S_WR2: begin
        ram_we        = 1'b1;
        ram_waddr     = addr_of(sig_r, HCNT_W'(fb_r));
        ram_wdata     = h1_r;
        out_valid_nxt = 1'b1;
      end

      S_DSCAN: begin
        if (qi_r != pcnt_r) begin
          qi_nxt = QCNT_W'(qi_r + 1'b1);
          if (q_blocked) begin
            // compact in place, the write index never passes the read index
            fifo_nxt[QIDX_W'(keep_r)] = q_sig;
            keep_nxt = QCNT_W'(keep_r + 1'b1);
          end else begin
            sig_nxt = q_sig;
            len_nxt = hcnt_r[q_sig];
            idx_nxt = '0;
          end
        end
      end

      S_DHAND: begin
        if (idx_r != len_r) begin
          ram_re  = 1'b1;
          rv_nxt  = 1'b1;
          idx_nxt = HCNT_W'(idx_r + 1'b1);
        end
        // one invocation is held back so the final one can carry last
        if (rv_r && int'(ninv_r) < MAX_RESULTS) begin
          ninv_nxt = RES_W'(ninv_r + 1'b1);
          if (hold_v_r) begin
            out_valid_nxt   = 1'b1;
            out_kind_nxt    = KIND_INVOKE;
            out_signal_nxt  = SIG_W'(hold_sig_r);
            out_handler_nxt = hold_h_r;
            out_pending_nxt = sat_pend(pfin_r);
            out_last_nxt    = 1'b0;
          end
          hold_v_nxt   = 1'b1;
          hold_sig_nxt = sig_r;
          hold_h_nxt   = ram_q;
        end
      end

      S_DEND: begin
        pcnt_nxt        = keep_r;
        hold_v_nxt      = 1'b0;
        out_valid_nxt   = 1'b1;
        out_pending_nxt = sat_pend(pfin_r);
        if (hold_v_r) begin
          out_kind_nxt    = KIND_INVOKE;
          out_signal_nxt  = SIG_W'(hold_sig_r);
          out_handler_nxt = hold_h_r;
        end else begin
          out_kind_nxt   = KIND_EMPTY;
          out_signal_nxt = '0;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      for (int i = 0; i < NUM_SIGNALS; i++) hcnt_r[i] <= '0;
      lblk_r      <= '0;
      gblk_r      <= '0;
      pcnt_r      <= '0;
      rv_r        <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hcnt_r      <= hcnt_nxt;
      lblk_r      <= lblk_nxt;
      gblk_r      <= gblk_nxt;
      pcnt_r      <= pcnt_nxt;
      rv_r        <= rv_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fifo_r        <= fifo_nxt;
    cmd_r         <= cmd_nxt;
    sig_r         <= sig_nxt;
    h1_r          <= h1_nxt;
    h2_r          <= h2_nxt;
    idx_r         <= idx_nxt;
    len_r         <= len_nxt;
    ridx_r        <= ridx_nxt;
    fa_r          <= fa_nxt;
    fb_r          <= fb_nxt;
    fav_r         <= fav_nxt;
    fbv_r         <= fbv_nxt;
    qi_r          <= qi_nxt;
    keep_r        <= keep_nxt;
    pfin_r        <= pfin_nxt;
    ninv_r        <= ninv_nxt;
    hold_sig_r    <= hold_sig_nxt;
    hold_h_r      <= hold_h_nxt;
    out_kind_r    <= out_kind_nxt;
    out_signal_r  <= out_signal_nxt;
    out_handler_r <= out_handler_nxt;
    out_status_r  <= out_status_nxt;
    out_pending_r <= out_pending_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_signal  = out_signal_r;
  assign out_handler = out_handler_r;
  assign out_status  = out_status_r;
  assign out_pending = out_pending_r;
  assign out_last    = out_last_r;

  `MSDQ_ASSERT_NXT(a_deliver_busy, clk, rst_n, start && !busy && in_cmd == CMD_DELIVER, busy)
  `MSDQ_ASSERT_IMP(a_more_results_busy, clk, rst_n, out_valid && !out_last, busy)
  `MSDQ_ASSERT_IMP(a_pcnt_range, clk, rst_n, 1'b1, int'(pcnt_r) <= QUEUE_DEPTH)
  `MSDQ_ASSERT_IMP(a_hold_in_deliver, clk, rst_n, hold_v_r, state_r >= S_DSCAN)

endmodule

/* sv/msdq_hram.sv */
// handler id memory: one write port, one registered read port
// depends on msdq_pkg
module msdq_hram #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [msdq_pkg::HID_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [msdq_pkg::HID_W-1:0] rdata
);
  import msdq_pkg::*;

  logic [HID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* tb/sv/masked_signal_dispatch_queue_tb.sv */
// testbench for masked_signal_dispatch_queue: directed and random command streams,
// results checked against an internal model of handler lists, block bits and signal queue
// depends on msdq_pkg and the masked_signal_dispatch_queue rtl
`timescale 1ns / 100ps
module masked_signal_dispatch_queue_tb;
  import msdq_pkg::*;

  localparam int NSIG = 16;
  localparam int QDEPTH = 8;
  localparam int MAXH = 4;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    kind_t kind;
    logic [SIG_W-1:0] sig;
    logic [HID_W-1:0] hid;
    status_t status;
    logic [PEND_W-1:0] pending;
    logic last;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] in_cmd = '0;
  logic [SIG_W-1:0] in_signal_num = '0;
  logic [HID_W-1:0] in_handler_first = '0;
  logic [HID_W-1:0] in_handler_second = '0;
  logic out_valid;
  logic [1:0] out_kind;
  logic [SIG_W-1:0] out_signal;
  logic [HID_W-1:0] out_handler;
  logic [1:0] out_status;
  logic [PEND_W-1:0] out_pending;
  logic out_last;

  // model state
  logic [HID_W-1:0] handlers [NSIG][MAXH];
  int hcount [NSIG];
  bit lblock [NSIG];
  bit gblock [NSIG];
  logic [SIG_W-1:0] sigq [$];

  outcome_t expected_q [$];
  int errors = 0;
  longint cycles = 0;
  int idle_pct = 32;

  masked_signal_dispatch_queue dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("masked_signal_dispatch_queue test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    outcome_t got, want;
    if (rst_n && out_valid) begin
      got = '{kind_t'(out_kind), out_signal, out_handler, status_t'(out_status),
              out_pending, out_last};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  function automatic int find_handler(int s, logic [HID_W-1:0] h);
    for (int i = 0; i < hcount[s]; i++)
      if (handlers[s][i] == h) return i;
    return -1;
  endfunction

  // compute the results one request causes and update the model
  task automatic predict_request(logic [CMD_W-1:0] c, logic [SIG_W-1:0] s,
                                 logic [HID_W-1:0] h1, logic [HID_W-1:0] h2);
    outcome_t res [$];
    logic [SIG_W-1:0] keep [$];
    status_t st;
    int a, b;
    st = ST_DONE;
    if (c == CMD_DELIVER) begin
      foreach (sigq[i]) begin
        if (lblock[sigq[i]] || gblock[sigq[i]]) keep.push_back(sigq[i]);
        else
          for (int j = 0; j < hcount[sigq[i]]; j++)
            if (res.size() < MAX_RESULTS)
              res.push_back('{KIND_INVOKE, sigq[i], handlers[sigq[i]][j], ST_DONE, 0, 0});
      end
      sigq = keep;
      if (res.size() == 0) res.push_back('{KIND_EMPTY, 0, 0, ST_DONE, 0, 0});
    end else begin
      if (c > CMD_DELIVER) st = ST_IGNORED;
      else case (cmd_t'(c))
        CMD_ADD: begin
          if (h1 == 0 || find_handler(int'(s), h1) >= 0) st = ST_IGNORED;
          else if (hcount[s] >= MAXH) st = ST_DROPPED;
          else begin
            handlers[s][hcount[s]] = h1;
            hcount[s]++;
          end
        end
        CMD_CLEAR: hcount[s] = 0;
        CMD_SWAP: begin
          a = find_handler(int'(s), h1);
          b = find_handler(int'(s), h2);
          if (a < 0 || b < 0 || a == b) st = ST_IGNORED;
          else begin
            handlers[s][a] = h2;
            handlers[s][b] = h1;
          end
        end
        CMD_BLOCK: lblock[s] = 1;
        CMD_UNBLOCK: lblock[s] = 0;
        CMD_GBLOCK: gblock[s] = 1;
        CMD_GUNBLOCK: gblock[s] = 0;
        default: begin
          if (hcount[s] == 0) st = ST_IGNORED;
          else if (sigq.size() >= QDEPTH) st = ST_DROPPED;
          else sigq.push_back(s);
        end
      endcase
      res.push_back('{KIND_ACK, s, 0, st, 0, 0});
    end
    foreach (res[k]) begin
      res[k].pending = PEND_W'(sigq.size());
      res[k].last = (k == res.size() - 1);
      expected_q.push_back(res[k]);
    end
  endtask

  // send one request: optional idle gap, then hold start until accepted
  task automatic send_request(logic [CMD_W-1:0] c, logic [SIG_W-1:0] s,
                              logic [HID_W-1:0] h1, logic [HID_W-1:0] h2);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_cmd <= c;
    in_signal_num <= s;
    in_handler_first <= h1;
    in_handler_second <= h2;
    do @(posedge clk); while (busy);
    predict_request(c, s, h1, h2);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic test_directed();
    send_request(CMD_DELIVER, 0, 0, 0);
    send_request(CMD_RAISE, 15, 0, 0);
    send_request(CMD_ADD, 15, 0, 0);
    send_request(CMD_ADD, 15, 8'hff, 0);
    send_request(CMD_ADD, 15, 8'hff, 0);
    for (int i = 1; i <= 5; i++) send_request(CMD_ADD, 0, HID_W'(i), 0);
    send_request(CMD_SWAP, 0, 1, 4);
    send_request(CMD_SWAP, 0, 2, 2);
    send_request(CMD_SWAP, 0, 2, 99);
    send_request(CMD_BLOCK, 15, 0, 0);
    send_request(CMD_GBLOCK, 0, 0, 0);
    send_request(CMD_RAISE, 15, 0, 0);
    send_request(CMD_RAISE, 0, 0, 0);
    send_request(CMD_DELIVER, 0, 0, 0);
    send_request(CMD_UNBLOCK, 15, 0, 0);
    send_request(CMD_GUNBLOCK, 0, 0, 0);
    send_request(4'hf, 3, 0, 0);
    send_request(4'h9, 3, 0, 0);
    send_request(CMD_DELIVER, 0, 0, 0);
    wait_drained();
  endtask

  // full queue, a raise of a signal with no handlers and the result limit, then a cleared signal still queued
  task automatic test_queue_limits();
    for (int s = 1; s < 9; s++)
      for (int h = 1; h <= 4; h++)
        send_request(CMD_ADD, SIG_W'(s), HID_W'(8'h10 * s + h), 0);
    for (int s = 1; s < 10; s++) send_request(CMD_RAISE, SIG_W'(s), 0, 0);
    send_request(CMD_ADD, 0, 7, 0);
    send_request(CMD_DELIVER, 4'hf, 8'hff, 8'hff);
    send_request(CMD_RAISE, 2, 0, 0);
    send_request(CMD_CLEAR, 2, 0, 0);
    send_request(CMD_DELIVER, 0, 0, 0);
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [CMD_W-1:0] c;
    logic [SIG_W-1:0] s;
    logic [HID_W-1:0] h1, h2;
    for (int n = 0; n < count; n++) begin
      idle_pct = (n >= 60 && n < 100) ? 0 : 32;
      if (n == 120) wait_drained();
      s = SIG_W'(($urandom_range(9) == 0) ? $urandom : $urandom_range(5));
      h1 = HID_W'(($urandom_range(9) == 0) ? $urandom : $urandom_range(6));
      h2 = HID_W'(($urandom_range(9) == 0) ? $urandom : $urandom_range(6));
      case ($urandom_range(19))
        0, 1, 2, 3: c = CMD_ADD;
        4: c = CMD_CLEAR;
        5, 6: c = CMD_SWAP;
        7: c = CMD_BLOCK;
        8: c = CMD_UNBLOCK;
        9: c = CMD_GBLOCK;
        10: c = CMD_GUNBLOCK;
        11, 12, 13, 14: c = CMD_RAISE;
        15, 16, 17: c = CMD_DELIVER;
        default: c = CMD_W'($urandom);
      endcase
      send_request(c, s, h1, h2);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    for (int i = 0; i < NSIG; i++) begin
      hcount[i] = 0;
      lblock[i] = 0;
      gblock[i] = 0;
    end
    test_directed();
    test_queue_limits();
    test_random(150);
    wait_drained();
    if (errors == 0 && expected_q.size() == 0)
      $display("masked_signal_dispatch_queue test passed");
    else
      $display("masked_signal_dispatch_queue test failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/msdq_pkg.sv
sv/msdq_hram.sv
sv/masked_signal_dispatch_queue.sv
tb/sv/masked_signal_dispatch_queue_tb.sv
